[src/spwm_pkg.sv]
`timescale 1ns / 1ps

package spwm_pkg;

	localparam int unsigned PERIOD_TICKS = 320000;

	localparam int CNT_W = $clog2(PERIOD_TICKS);
	localparam int FLD_W = 19;
	localparam int W_W   = (CNT_W > FLD_W) ? CNT_W : FLD_W;
	localparam int ANG_W = 8;
	localparam int STP_W = 16;
	localparam int MS_W  = 16;
	localparam int OUT_W = 16;

	localparam logic [CNT_W-1:0] LOAD_C = CNT_W'(PERIOD_TICKS - 1);
	localparam logic [W_W-1:0]   LOAD_W = W_W'(PERIOD_TICKS - 1);
	localparam logic [W_W-1:0]   RST_WIDTH =
		(24000 > PERIOD_TICKS - 1) ? LOAD_W : W_W'(24000);

	localparam logic [FLD_W-1:0] RST_MIN  = FLD_W'(12000);
	localparam logic [FLD_W-1:0] RST_MAX  = FLD_W'(36000);
	localparam logic [STP_W-1:0] RST_STEP = STP_W'(150);
	localparam logic [MS_W-1:0]  RST_MOVE = MS_W'(800);

	localparam logic [ANG_W-1:0] ANG_MAX  = ANG_W'(180);
	localparam int               ANG_HALF = 90;

	// angle * span + 90, then floor(x / 180) = ((x >> 2) * ceil(2^31 / 45)) >> 31,
	// exact for x below 2^27
	localparam int RND_W   = ANG_W + FLD_W;
	localparam int RECIP_K = 31;

	localparam int MUL_A_W = RND_W - 2;
	localparam int MUL_B_W = 26;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;
	localparam logic [MUL_B_W-1:0] RECIP_M = MUL_B_W'(47721859);

	localparam int DIV_W   = W_W + MS_W;
	localparam int DVS_W   = FLD_W;
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_MIN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
	localparam logic [1:0] REG_STEP_TICKS = 2'd2;
	localparam logic [1:0] REG_MOVE_MS    = 2'd3;

	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_SET_WIDTH = 3'd1;
	localparam logic [2:0] CMD_SET_ANGLE = 3'd2;
	localparam logic [2:0] CMD_STEP_UP   = 3'd3;
	localparam logic [2:0] CMD_STEP_DOWN = 3'd4;

	typedef struct packed {
		logic [2:0]       command;
		logic [FLD_W-1:0] value;
	} in_beat_t;

	typedef struct packed {
		logic             pwm_level;
		logic [FLD_W-1:0] requested_width;
		logic [FLD_W-1:0] active_width;
		logic [OUT_W-1:0] move_wait_ms;
		logic             period_start;
	} out_beat_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_stat_t;

	typedef struct packed {
		logic           level;
		logic           start;
		logic [W_W-1:0] live;
	} tmr_stat_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL1  = 8'b0000_0010,
		ST_RECIP = 8'b0000_0100,
		ST_TGT   = 8'b0000_1000,
		ST_DIFF  = 8'b0001_0000,
		ST_MUL2  = 8'b0010_0000,
		ST_DIV2  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	function automatic logic [W_W-1:0] clamp_width(input logic [W_W:0] w);
		logic [W_W-1:0] r;
		if (w > {1'b0, LOAD_W}) begin
			r = LOAD_W;
		end else if (w == '0) begin
			r = W_W'(1);
		end else begin
			r = w[W_W-1:0];
		end
		return r;
	endfunction

endpackage

[src/spwm_div.sv]
`timescale 1ns / 1ps

module spwm_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spwm_pkg::div_req_t   req,
	output spwm_pkg::div_stat_t  stat
);

	logic [spwm_pkg::DIV_W-1:0]  quot_q;
	logic [spwm_pkg::DVS_W-1:0]  rem_q;
	logic [spwm_pkg::DVS_W-1:0]  dvs_q;
	logic [spwm_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [spwm_pkg::DVS_W:0]    rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q, quot_q[spwm_pkg::DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= spwm_pkg::DCNT_W'(spwm_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == spwm_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[spwm_pkg::DIV_W-2:0], fits};
			rem_q  <= fits ? spwm_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
			               : rem_sh[spwm_pkg::DVS_W-1:0];
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quot_q;

endmodule

[src/spwm_timer.sv]
`timescale 1ns / 1ps

module spwm_timer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick,
	input  logic [spwm_pkg::W_W-1:0]   pend,
	output spwm_pkg::tmr_stat_t        stat
);

	logic [spwm_pkg::CNT_W-1:0] count_q;
	logic [spwm_pkg::W_W-1:0]   live_q;
	logic [spwm_pkg::CNT_W-1:0] count_nxt;
	logic [spwm_pkg::W_W-1:0]   live_nxt;
	logic                       wrap;

	assign wrap      = tick && (count_q == '0);
	assign count_nxt = wrap ? spwm_pkg::LOAD_C : (tick ? count_q - 1'b1 : count_q);
	assign live_nxt  = wrap ? pend : live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= spwm_pkg::LOAD_C;
			live_q  <= spwm_pkg::RST_WIDTH;
		end else begin
			count_q <= count_nxt;
			live_q  <= live_nxt;
		end
	end

	assign stat.start = wrap;
	assign stat.live  = live_nxt;
	assign stat.level = ((spwm_pkg::W_W+1)'(count_nxt) + (spwm_pkg::W_W+1)'(live_nxt))
	                    > {1'b0, spwm_pkg::LOAD_W};

endmodule

[src/servo_pwm_angle_controller_core.sv]
`timescale 1ns / 1ps

// channel | handshake           | payload
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_stall | in_data: command, value
// out     | out_valid/out_stall | out_data: level, widths, move wait, start
// cfg     | APB psel/penable    | paddr[3:2] selects min, max, step, move ms
//
// Tick, set width, step and unknown commands go from idle straight to finish.
// Set angle: two shared multiplier passes for the angle mapping (divide by 180 as
// a reciprocal product), then the restoring divider for the move wait, one quotient
// bit a cycle. When span <= 0 the move wait and its divide are skipped.
// Reset restores calibration defaults, the period count and both widths.
// A beat is taken while a result waits; the next result holds until out_stall drops.

module servo_pwm_angle_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  spwm_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output spwm_pkg::out_beat_t            out_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [spwm_pkg::PADDR_W-1:0]   paddr,
	input  logic [spwm_pkg::PDATA_W-1:0]   pwdata,
	output logic [spwm_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [spwm_pkg::FLD_W-1:0] min_q;
	logic [spwm_pkg::FLD_W-1:0] max_q;
	logic [spwm_pkg::STP_W-1:0] step_q;
	logic [spwm_pkg::MS_W-1:0]  move_q;

	spwm_pkg::state_t           state_q;
	logic [2:0]                 cmd_q;
	logic [spwm_pkg::FLD_W-1:0] val_q;
	logic [spwm_pkg::ANG_W-1:0] ang_q;
	logic                       neg_q;
	logic [spwm_pkg::FLD_W-1:0] mag_q;
	logic [spwm_pkg::FLD_W-1:0] target_q;
	logic [spwm_pkg::W_W-1:0]   diff_q;
	logic [spwm_pkg::MUL_W-1:0] mul_q;
	logic [spwm_pkg::OUT_W-1:0] wait_q;
	logic                       div_go_q;
	logic [spwm_pkg::W_W-1:0]   pending_q;
	logic                       out_valid_q;
	spwm_pkg::out_beat_t        out_q;

	logic                         accept;
	logic                         fin_go;
	logic                         cfg_wr;
	logic [1:0]                   cfg_idx;
	logic [spwm_pkg::RND_W-1:0]   rnd_sum;
	logic [spwm_pkg::FLD_W-1:0]   q_w;
	logic [spwm_pkg::MUL_A_W-1:0] mul_a;
	logic [spwm_pkg::MUL_B_W-1:0] mul_b;
	logic [spwm_pkg::MUL_W-1:0]   mul_p;
	logic [spwm_pkg::W_W-1:0]     pend_nxt;
	logic [spwm_pkg::W_W-1:0]     tgt_w;
	spwm_pkg::div_req_t           div_req;
	spwm_pkg::div_stat_t          div_stat;
	spwm_pkg::tmr_stat_t          tmr_stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= spwm_pkg::RST_MIN;
			max_q  <= spwm_pkg::RST_MAX;
			step_q <= spwm_pkg::RST_STEP;
			move_q <= spwm_pkg::RST_MOVE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				spwm_pkg::REG_MIN_WIDTH:  min_q  <= pwdata[spwm_pkg::FLD_W-1:0];
				spwm_pkg::REG_MAX_WIDTH:  max_q  <= pwdata[spwm_pkg::FLD_W-1:0];
				spwm_pkg::REG_STEP_TICKS: step_q <= pwdata[spwm_pkg::STP_W-1:0];
				spwm_pkg::REG_MOVE_MS:    move_q <= pwdata[spwm_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			spwm_pkg::REG_MIN_WIDTH:  prdata = spwm_pkg::PDATA_W'(min_q);
			spwm_pkg::REG_MAX_WIDTH:  prdata = spwm_pkg::PDATA_W'(max_q);
			spwm_pkg::REG_STEP_TICKS: prdata = spwm_pkg::PDATA_W'(step_q);
			spwm_pkg::REG_MOVE_MS:    prdata = spwm_pkg::PDATA_W'(move_q);
			default:                  prdata = '0;
		endcase
	end

	assign in_stall = (state_q != spwm_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_go   = (state_q == spwm_pkg::ST_FIN) && (!out_valid_q || !out_stall);

	// angle * span + 90, quarter taken ahead of the reciprocal of 45
	assign rnd_sum = spwm_pkg::RND_W'(mul_q) + spwm_pkg::RND_W'(spwm_pkg::ANG_HALF);
	assign q_w     = mul_q[spwm_pkg::RECIP_K +: spwm_pkg::FLD_W];

	// shared multiplier: angle * span, reciprocal, then distance * move time
	always_comb begin
		case (state_q)
			spwm_pkg::ST_MUL1: begin
				mul_a = spwm_pkg::MUL_A_W'(ang_q);
				mul_b = spwm_pkg::MUL_B_W'(mag_q);
			end
			spwm_pkg::ST_RECIP: begin
				mul_a = rnd_sum[spwm_pkg::RND_W-1:2];
				mul_b = spwm_pkg::RECIP_M;
			end
			default: begin
				mul_a = spwm_pkg::MUL_A_W'(diff_q);
				mul_b = spwm_pkg::MUL_B_W'(move_q);
			end
		endcase
	end
	assign mul_p = spwm_pkg::MUL_W'(mul_a) * spwm_pkg::MUL_W'(mul_b);

	assign div_req.start    = div_go_q;
	assign div_req.dividend = spwm_pkg::DIV_W'(mul_q);
	assign div_req.divisor  = mag_q;

	spwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spwm_pkg::ST_IDLE;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
				spwm_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= (in_data.command == spwm_pkg::CMD_SET_ANGLE)
							? spwm_pkg::ST_MUL1 : spwm_pkg::ST_FIN;
					end
				end
				spwm_pkg::ST_MUL1: begin
					state_q <= spwm_pkg::ST_RECIP;
				end
				spwm_pkg::ST_RECIP: begin
					state_q <= spwm_pkg::ST_TGT;
				end
				spwm_pkg::ST_TGT: begin
					state_q <= (!neg_q && mag_q != '0) ? spwm_pkg::ST_DIFF : spwm_pkg::ST_FIN;
				end
				spwm_pkg::ST_DIFF: begin
					state_q <= spwm_pkg::ST_MUL2;
				end
				spwm_pkg::ST_MUL2: begin
					div_go_q <= 1'b1;
					state_q  <= spwm_pkg::ST_DIV2;
				end
				spwm_pkg::ST_DIV2: begin
					if (div_stat.done) begin
						state_q <= spwm_pkg::ST_FIN;
					end
				end
				spwm_pkg::ST_FIN: begin
					if (fin_go) begin
						state_q <= spwm_pkg::ST_IDLE;
					end
				end
				default: state_q <= spwm_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_data.command;
			val_q  <= in_data.value;
			ang_q  <= (in_data.value > spwm_pkg::FLD_W'(spwm_pkg::ANG_MAX))
				? spwm_pkg::ANG_MAX : in_data.value[spwm_pkg::ANG_W-1:0];
			neg_q  <= max_q < min_q;
			mag_q  <= (max_q < min_q) ? min_q - max_q : max_q - min_q;
			wait_q <= '0;
		end
		if (state_q == spwm_pkg::ST_MUL1 || state_q == spwm_pkg::ST_RECIP
				|| state_q == spwm_pkg::ST_MUL2) begin
			mul_q <= mul_p;
		end
		if (state_q == spwm_pkg::ST_TGT) begin
			target_q <= neg_q ? min_q - q_w : min_q + q_w;
		end
		if (state_q == spwm_pkg::ST_DIFF) begin
			diff_q <= (tgt_w > pending_q) ? tgt_w - pending_q : pending_q - tgt_w;
		end
		if (state_q == spwm_pkg::ST_DIV2 && div_stat.done) begin
			wait_q <= (|div_stat.quotient[spwm_pkg::DIV_W-1:spwm_pkg::OUT_W])
				? '1 : div_stat.quotient[spwm_pkg::OUT_W-1:0];
		end
	end

	assign tgt_w = spwm_pkg::W_W'(target_q);

	always_comb begin
		case (cmd_q)
			spwm_pkg::CMD_SET_WIDTH:
				pend_nxt = spwm_pkg::clamp_width((spwm_pkg::W_W+1)'(val_q));
			spwm_pkg::CMD_SET_ANGLE:
				pend_nxt = spwm_pkg::clamp_width((spwm_pkg::W_W+1)'(target_q));
			spwm_pkg::CMD_STEP_UP:
				pend_nxt = spwm_pkg::clamp_width((spwm_pkg::W_W+1)'(pending_q)
					+ (spwm_pkg::W_W+1)'(step_q));
			spwm_pkg::CMD_STEP_DOWN:
				pend_nxt = (pending_q > spwm_pkg::W_W'(step_q))
					? spwm_pkg::clamp_width((spwm_pkg::W_W+1)'(pending_q
						- spwm_pkg::W_W'(step_q)))
					: spwm_pkg::clamp_width('0);
			default:
				pend_nxt = pending_q;
		endcase
	end

	spwm_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (fin_go && cmd_q == spwm_pkg::CMD_TICK),
		.pend   (pending_q),
		.stat   (tmr_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= spwm_pkg::RST_WIDTH;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				pending_q   <= pend_nxt;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.pwm_level       <= tmr_stat.level;
			out_q.requested_width <= pend_nxt[spwm_pkg::FLD_W-1:0];
			out_q.active_width    <= tmr_stat.live[spwm_pkg::FLD_W-1:0];
			out_q.move_wait_ms    <= wait_q;
			out_q.period_start    <= tmr_stat.start;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == spwm_pkg::ST_FIN))
		else $error("result raised outside finish state");

	a_div_go_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (state_q == spwm_pkg::ST_DIV2))
		else $error("divider started outside the divide state");

	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != '0)
		else $error("pending width reached zero");

endmodule
